FILE: rtl/bbl_pkg.sv
// Shared types and constants for the 3x3 RGB box blur.
// No dependencies; every other file of the block takes its names from here.
`default_nettype none

package bbl_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int CHAN_W         = 8;
    localparam int PIXEL_W        = 3 * CHAN_W;
    localparam int ROW_W          = 16;
    localparam int NUM_TAPS       = 9;
    localparam int SUM_W          = 12;   // holds 9 * 255

    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 16;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 16;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

    // floor(2^16 / d) for the rounding divides by 6 and by 18
    localparam int RECIP_SHIFT = 16;
    localparam logic [13:0] RECIP_6  = 14'd10922;
    localparam logic [11:0] RECIP_18 = 12'd3640;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        TAPS_4,
        TAPS_6,
        TAPS_9
    } tap_count_t;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } rgb_t;

    typedef struct packed {
        op_t               operation;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              frame_last;
    } result_t;

    typedef struct packed {
        logic                load;
        logic [NUM_TAPS-1:0] mask;
        tap_count_t          count;
    } lane_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/bbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on bbl_pkg for its default sizes.
`default_nettype none

module bbl_ram #(
    parameter int WIDTH = bbl_pkg::PIXEL_W,
    parameter int DEPTH = bbl_pkg::MAX_WIDTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bbl_lane.sv
// One colour lane: masked 3x3 sum, registered, then rounded mean.
// Depends on bbl_pkg (lane_ctrl_t, reciprocal constants).
`default_nettype none

module bbl_lane (
    input  wire logic                                             clk,
    input  wire bbl_pkg::lane_ctrl_t                              ctrl,
    input  wire logic [bbl_pkg::NUM_TAPS-1:0][bbl_pkg::CHAN_W-1:0] taps,
    output logic      [bbl_pkg::CHAN_W-1:0]                       mean
);

    localparam int SW = bbl_pkg::SUM_W;

    logic [SW-1:0]       sum_next;
    logic [SW-1:0]       sum_reg;
    bbl_pkg::tap_count_t count_reg;

    logic [SW-1:0] y4;
    logic [SW-1:0] y6;
    logic [25:0]   p6;
    logic [9:0]    q6;
    logic [SW:0]   r6;
    logic [9:0]    q6_fix;
    logic [SW:0]   y9;
    logic [24:0]   p9;
    logic [8:0]    q9;
    logic [SW+1:0] r9;
    logic [8:0]    q9_fix;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < bbl_pkg::NUM_TAPS; i++)
        begin
            if (ctrl.mask[i])
            begin
                sum_next = sum_next + SW'(taps[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sum_reg   <= sum_next;
            count_reg <= ctrl.count;
        end
    end

    // mean = floor((2s + n) / 2n); reciprocal estimate is low by at most one
    always_comb
    begin
        y4 = sum_reg + SW'(2);

        y6     = sum_reg + SW'(3);
        p6     = 26'(y6) * 26'(bbl_pkg::RECIP_6);
        q6     = p6[bbl_pkg::RECIP_SHIFT +: 10];
        r6     = (SW+1)'(y6) - ((SW+1)'(q6) << 2) - ((SW+1)'(q6) << 1);
        q6_fix = (r6 >= (SW+1)'(6)) ? q6 + 10'd1 : q6;

        y9     = {sum_reg, 1'b0} + (SW+1)'(9);
        p9     = 25'(y9) * 25'(bbl_pkg::RECIP_18);
        q9     = p9[bbl_pkg::RECIP_SHIFT +: 9];
        r9     = (SW+2)'(y9) - ((SW+2)'(q9) << 4) - ((SW+2)'(q9) << 1);
        q9_fix = (r9 >= (SW+2)'(18)) ? q9 + 9'd1 : q9;

        case (count_reg)
            bbl_pkg::TAPS_4: mean = y4[2 +: bbl_pkg::CHAN_W];
            bbl_pkg::TAPS_6: mean = q6_fix[bbl_pkg::CHAN_W-1:0];
            bbl_pkg::TAPS_9: mean = q9_fix[bbl_pkg::CHAN_W-1:0];
            default:         mean = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/box_blur_3x3_rgb.sv
// Streaming 3x3 box blur of RGB frames: line stores, window, three colour lanes.
// Depends on bbl_pkg, bbl_ram and bbl_lane.
//
// Use:
//   pixel channel  - pixel_valid / pixel_stall / pixel. Send the frame in raster
//                    order (operation = pixel), then width+1 drain items
//                    (operation = drain) to flush the remaining results.
//   result channel - result_valid / result_stall / result. One result per pixel,
//                    in raster order; frame_last marks the frame's final pixel.
//   cfg channel    - cfg_valid / cfg_ready / cfg_index / cfg_data. Always ready.
//                    Write frame_width and frame_height only while idle.
// Throughput: one item per clock while pixel_stall is low.
// Order: the result for pixel (r, c) is released by the item for (r+1, c+1),
//   i.e. one line plus one pixel later; it then passes the line store read, the
//   lane sum register and the result register before it shows on the result port.
// Reset: counters, window and config return to defaults (640 x 480). The line
//   stores need no clearing pass; only masked window taps can see stale entries.
// Stall: a stalled result holds. The pipeline keeps taking items unless a
//   stalled result has a pending result in lane stage C behind it; then
//   pixel_stall rises in the same cycle.
// Out-of-place items (pixel after the frame is complete, drain before it is)
//   are accepted and dropped.
`default_nettype none

module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH = bbl_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // pixel items in
    input  wire logic                               pixel_valid,
    output logic                                    pixel_stall,
    input  wire bbl_pkg::pixel_t                    pixel,
    // blurred items out
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output bbl_pkg::result_t                        result,
    // register writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bbl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bbl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);      // column index
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);  // holds the width itself
    localparam int ROW_W  = bbl_pkg::ROW_W;
    localparam int IROW_W = ROW_W + 1;              // input row counts drain rows
    localparam int WIN    = 3;
    localparam int CW     = bbl_pkg::CHAN_W;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [bbl_pkg::FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [bbl_pkg::FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic [WCNT_W-1:0]                  w_eff;
    logic [ROW_W-1:0]                   h_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= bbl_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= bbl_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (bbl_pkg::cfg_reg_t'(cfg_index))
                bbl_pkg::REG_FRAME_WIDTH:
                    frame_width_reg  <= cfg_data[bbl_pkg::FRAME_WIDTH_W-1:0];
                bbl_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data[bbl_pkg::FRAME_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp width to [2, MAX_WIDTH], height to at least 2
    always_comb
    begin
        if (frame_width_reg < bbl_pkg::FRAME_WIDTH_W'(2))
        begin
            w_eff = WCNT_W'(2);
        end
        else if (32'(frame_width_reg) > MAX_WIDTH)
        begin
            w_eff = WCNT_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WCNT_W'(frame_width_reg);
        end
        h_eff = (frame_height_reg < ROW_W'(2)) ? ROW_W'(2) : frame_height_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline control: freeze only when a result would overwrite a
    // stalled one.
    // ------------------------------------------------------------------
    logic result_valid_reg;
    logic c_valid_reg;
    logic advance;
    logic accept;

    assign advance     = !(result_valid_reg && result_stall && c_valid_reg);
    assign pixel_stall = !advance;
    assign accept      = pixel_valid && !pixel_stall;

    // ------------------------------------------------------------------
    // Accept stage: position counters and item decisions
    // ------------------------------------------------------------------
    logic [COL_W-1:0]  in_col_reg,  in_col_next;
    logic [IROW_W-1:0] in_row_reg,  in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;

    logic              is_drain;
    logic              rows_done;
    logic              live;
    logic              emit;
    logic              row_start;
    logic [WCNT_W-1:0] col_inc;
    logic [WCNT_W-1:0] oc_inc;
    logic [IROW_W-1:0] or_inc;
    logic              row_top_ok, row_bot_ok, col_left_ok, col_right_ok;
    logic              last;
    logic [WIN-1:0]    row_ok, col_ok;
    logic [bbl_pkg::NUM_TAPS-1:0] mask;
    bbl_pkg::tap_count_t          count;
    bbl_pkg::rgb_t                px_in;

    always_comb
    begin
        is_drain  = (pixel.operation == bbl_pkg::OP_DRAIN);
        rows_done = (in_row_reg >= IROW_W'(h_eff));
        // pixels after the frame and drains during it are dropped
        live      = accept && (is_drain ? rows_done : !rows_done);
        emit      = (in_row_reg >= IROW_W'(2))
                    || ((in_row_reg == IROW_W'(1)) && (in_col_reg != '0));
        row_start = (in_col_reg == '0);

        px_in.r = is_drain ? '0 : pixel.red_in;
        px_in.g = is_drain ? '0 : pixel.green_in;
        px_in.b = is_drain ? '0 : pixel.blue_in;

        col_inc = WCNT_W'(in_col_reg) + WCNT_W'(1);
        oc_inc  = WCNT_W'(out_col_reg) + WCNT_W'(1);
        or_inc  = IROW_W'(out_row_reg) + IROW_W'(1);

        row_top_ok   = (out_row_reg != '0);
        row_bot_ok   = (or_inc < IROW_W'(h_eff));
        col_left_ok  = (out_col_reg != '0);
        col_right_ok = (oc_inc < w_eff);
        last         = !row_bot_ok && !col_right_ok;

        row_ok = {row_bot_ok, 1'b1, row_top_ok};
        col_ok = {col_right_ok, 1'b1, col_left_ok};
        for (int r = 0; r < WIN; r++)
        begin
            for (int c = 0; c < WIN; c++)
            begin
                mask[r * WIN + c] = row_ok[r] && col_ok[c];
            end
        end

        if (row_top_ok && row_bot_ok && col_left_ok && col_right_ok)
        begin
            count = bbl_pkg::TAPS_9;
        end
        else if ((row_top_ok && row_bot_ok) || (col_left_ok && col_right_ok))
        begin
            count = bbl_pkg::TAPS_6;
        end
        else
        begin
            count = bbl_pkg::TAPS_4;
        end

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (live)
        begin
            if (col_inc >= w_eff)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + IROW_W'(1);
            end
            else
            begin
                in_col_next = col_inc[COL_W-1:0];
            end
            if (emit)
            begin
                if (last)
                begin
                    // frame complete: everything starts over
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (!col_right_ok)
                begin
                    out_col_next = '0;
                    out_row_next = or_inc[ROW_W-1:0];
                end
                else
                begin
                    out_col_next = oc_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ------------------------------------------------------------------
    // Window stage (B): line store data arrives, window shifts
    // ------------------------------------------------------------------
    logic                         b_valid_reg;
    logic                         b_emit_reg;
    logic                         b_last_reg;
    logic                         b_row_start_reg;
    bbl_pkg::rgb_t                b_px_reg;
    logic [COL_W-1:0]             b_idx_reg;
    logic [bbl_pkg::NUM_TAPS-1:0] b_mask_reg;
    bbl_pkg::tap_count_t          b_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= live;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_emit_reg      <= emit;
            b_last_reg      <= last;
            b_row_start_reg <= row_start;
            b_px_reg        <= px_in;
            b_idx_reg       <= in_col_reg;
            b_mask_reg      <= mask;
            b_count_reg     <= count;
        end
    end

    // line stores: read at accept, written back when the item leaves B
    logic                         ls_wr_en;
    logic [bbl_pkg::PIXEL_W-1:0]  older_q, newer_q;
    bbl_pkg::rgb_t                top_px, mid_px;
    logic                         byp_valid_reg;
    bbl_pkg::rgb_t                byp_older_reg, byp_newer_reg;

    assign ls_wr_en = b_valid_reg && advance;

    bbl_ram #(
        .WIDTH (bbl_pkg::PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_older_ram (
        .clk     (clk),
        .wr_en   (ls_wr_en),
        .wr_addr (b_idx_reg),
        .wr_data (mid_px),
        .rd_en   (advance),
        .rd_addr (in_col_reg),
        .rd_data (older_q)
    );

    bbl_ram #(
        .WIDTH (bbl_pkg::PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_newer_ram (
        .clk     (clk),
        .wr_en   (ls_wr_en),
        .wr_addr (b_idx_reg),
        .wr_data (b_px_reg),
        .rd_en   (advance),
        .rd_addr (in_col_reg),
        .rd_data (newer_q)
    );

    // same column read while it is written: forward the fresh write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            byp_valid_reg <= ls_wr_en && (b_idx_reg == in_col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byp_older_reg <= mid_px;
            byp_newer_reg <= b_px_reg;
        end
    end

    assign top_px = byp_valid_reg ? byp_older_reg : bbl_pkg::rgb_t'(older_q);
    assign mid_px = byp_valid_reg ? byp_newer_reg : bbl_pkg::rgb_t'(newer_q);

    bbl_pkg::rgb_t [WIN-1:0][WIN-1:0] win_reg, win_next, view;
    logic [WIN-1:0][bbl_pkg::NUM_TAPS-1:0][CW-1:0] lane_taps;

    always_comb
    begin
        for (int r = 0; r < WIN; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = top_px;
        win_next[1][2] = mid_px;
        win_next[2][2] = b_px_reg;

        // at a row start the pending result is the previous row's last
        // column, so use the window as it stood before the shift
        for (int r = 0; r < WIN; r++)
        begin
            if (b_row_start_reg)
            begin
                view[r][0] = win_reg[r][1];
                view[r][1] = win_reg[r][2];
                view[r][2] = '0;
            end
            else
            begin
                view[r] = win_next[r];
            end
        end

        for (int ch = 0; ch < WIN; ch++)
        begin
            for (int r = 0; r < WIN; r++)
            begin
                for (int c = 0; c < WIN; c++)
                begin
                    lane_taps[ch][r * WIN + c] = view[r][c][ch * CW +: CW];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (b_valid_reg && advance)
        begin
            win_reg <= win_next;
        end
    end

    // ------------------------------------------------------------------
    // Lane stage (C): one lane per colour; lane 2 red, 1 green, 0 blue
    // ------------------------------------------------------------------
    bbl_pkg::lane_ctrl_t  lane_ctrl;
    logic [WIN-1:0][CW-1:0] lane_mean;
    logic                 c_last_reg;

    always_comb
    begin
        lane_ctrl.load  = advance && b_valid_reg && b_emit_reg;
        lane_ctrl.mask  = b_mask_reg;
        lane_ctrl.count = b_count_reg;
    end

    for (genvar ch = 0; ch < WIN; ch++)
    begin : g_lane
        bbl_lane u_lane (
            .clk  (clk),
            .ctrl (lane_ctrl),
            .taps (lane_taps[ch]),
            .mean (lane_mean[ch])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            c_valid_reg <= b_valid_reg && b_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_last_reg <= b_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Merge: the three lane means and the frame mark form one result item
    // ------------------------------------------------------------------
    bbl_pkg::result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance && c_valid_reg)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && c_valid_reg)
        begin
            result_reg.red_out    <= lane_mean[2];
            result_reg.green_out  <= lane_mean[1];
            result_reg.blue_out   <= lane_mean[0];
            result_reg.frame_last <= c_last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

FILE: rtl/bbl_checker.sv
// Port-level checks for box_blur_3x3_rgb, attached by the bind at the end.
// Depends on bbl_pkg for the payload types.
`default_nettype none

module bbl_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             pixel_valid,
    input wire logic             pixel_stall,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire bbl_pkg::result_t result
);

    // input only backs up behind a stalled result
    a_stall_cause: assert property (
        @(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (result_valid && result_stall)
    ) else $error("pixel_stall raised without a stalled result");

    // a stalled result keeps its item
    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result))
    ) else $error("stalled result dropped or changed");

    // a result needs an item taken earlier
    a_min_latency: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!result_valid && !$past(result_valid) && !$past(result_valid, 2)
         && !$past(pixel_valid && !pixel_stall, 2))
        |=> !result_valid
    ) else $error("result appeared without a feeding item");

endmodule

bind box_blur_3x3_rgb bbl_checker u_bbl_checker (.*);

`default_nettype wire
